/* sv/cmap_segment_glyph_lookup_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the segmented character map lookup
// Shared property forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CMAP_SEGMENT_GLYPH_LOOKUP_ASSERT_SVH
`define CMAP_SEGMENT_GLYPH_LOOKUP_ASSERT_SVH

// same-cycle implication
`define CMAP_SEG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CMAP_SEG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/cmap_seg_pkg.sv */
// ----------------------------------------------------------------------------
// cmap_seg_pkg
// Types and fixed widths shared by the segmented character map lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package cmap_seg_pkg;

	localparam int WORD_W     = 16;
	localparam int ADDR_IN_W  = 11;
	localparam int SEGCNT_W   = 9;

	// op codes carried in s_tuser
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_MAPPED    = 2'd0,
		ST_NO_SEG    = 2'd1,
		ST_RANGE_ERR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_GCHK,
		S_GWAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0] glyph_id;
		status_t           status;
	} result_t;

endpackage

`default_nettype wire

/* sv/cmap_segment_glyph_lookup.sv */
// ----------------------------------------------------------------------------
// cmap_segment_glyph_lookup
// Format-4 segmented character map lookup over a word table held in RAM.
// ----------------------------------------------------------------------------
// A write transfer (tuser 0) stores one table word. A lookup transfer
// (tuser 1) scans the segment records at one record per cycle, the table
// being held twice with two read ports each so that end, start, delta and
// range offset come out together. A lookup that matches a segment takes its
// glyph from code point plus delta when the range offset is zero, else from
// the glyph array word after an address check; a scan that matches nothing
// ends after segment_count records (segment_count capped at MAX_SEGMENTS).
// No transfer is taken while a lookup is in progress, so the next transfer
// is taken only once the result is loaded. Results sit in an output register,
// so the next transfer is taken while one result waits; a second finished
// lookup holds the input off until that register drains. The table has no
// reset; a lookup must touch only words already written. segment_count must
// be written only while the block is idle; the block does not enforce it.
`default_nettype none

module cmap_segment_glyph_lookup #(
	parameter int TABLE_WORDS  = 2048,
	parameter int MAX_SEGMENTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // word_address[10:0], word_data[26:11], code_point[42:27]
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // glyph_id[15:0]
	output logic [1:0]  m_tuser,   // status[1:0]
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data
);

	import cmap_seg_pkg::*;

	localparam int AW = $clog2(TABLE_WORDS);
	localparam int XW = ((AW > ADDR_IN_W) ? AW : ADDR_IN_W) + 2;

	logic [SEGCNT_W-1:0]  seg_cnt_q;
	logic                 s_xfer;
	logic                 idle;
	logic                 wr_en;
	logic [XW-1:0]        wa_ext;
	logic [ADDR_IN_W-1:0] word_address;
	logic [WORD_W-1:0]    word_data, code_point;
	logic [AW-1:0]        ra_end, ra_start, ra_delta, ra_off;
	logic [WORD_W-1:0]    rd_end, rd_start, rd_delta, rd_off;
	logic                 res_valid, res_ready;
	result_t              res;
	logic                 m_tvalid_q;
	result_t              out_q;

	assign word_address = s_tdata[10:0];
	assign word_data    = s_tdata[26:11];
	assign code_point   = s_tdata[42:27];

	assign s_tready = idle;
	assign s_xfer   = s_tvalid && s_tready;
	assign wa_ext   = XW'(word_address);
	assign wr_en    = s_xfer && (s_tuser == OP_WRITE) && (wa_ext < XW'(TABLE_WORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt_q <= SEGCNT_W'(1);
		end else if (cfg_wr_en) begin
			seg_cnt_q <= cfg_wr_data;
		end
	end

	cmap_seg_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_WORDS)) u_ram_a (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (wa_ext[AW-1:0]),
		.wdata  (word_data),
		.raddr0 (ra_end),
		.raddr1 (ra_start),
		.rdata0 (rd_end),
		.rdata1 (rd_start)
	);

	cmap_seg_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_WORDS)) u_ram_b (
		.clk    (clk),
		.we     (wr_en),
		.waddr  (wa_ext[AW-1:0]),
		.wdata  (word_data),
		.raddr0 (ra_delta),
		.raddr1 (ra_off),
		.rdata0 (rd_delta),
		.rdata1 (rd_off)
	);

	cmap_seg_ctrl #(.TABLE_WORDS(TABLE_WORDS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_xfer && (s_tuser == OP_LOOKUP)),
		.code_in   (code_point),
		.seg_cnt   (seg_cnt_q),
		.idle      (idle),
		.ra_end    (ra_end),
		.ra_start  (ra_start),
		.ra_delta  (ra_delta),
		.ra_off    (ra_off),
		.rd_end    (rd_end),
		.rd_start  (rd_start),
		.rd_delta  (rd_delta),
		.rd_off    (rd_off),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q.glyph_id;
	assign m_tuser  = out_q.status;

endmodule

`default_nettype wire

/* sv/cmap_seg_ram.sv */
// ----------------------------------------------------------------------------
// cmap_seg_ram
// Generic word RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cmap_seg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

`default_nettype wire

/* sv/cmap_seg_ctrl.sv */
// ----------------------------------------------------------------------------
// cmap_seg_ctrl
// Lookup sequencer: segment scan, one record per cycle, then glyph word read.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cmap_segment_glyph_lookup_assert.svh"

module cmap_seg_ctrl #(
	parameter int TABLE_WORDS  = 2048,
	parameter int MAX_SEGMENTS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [cmap_seg_pkg::WORD_W-1:0]      code_in,
	input  logic [cmap_seg_pkg::SEGCNT_W-1:0]    seg_cnt,
	output logic                                 idle,
	output logic [$clog2(TABLE_WORDS)-1:0]       ra_end,
	output logic [$clog2(TABLE_WORDS)-1:0]       ra_start,
	output logic [$clog2(TABLE_WORDS)-1:0]       ra_delta,
	output logic [$clog2(TABLE_WORDS)-1:0]       ra_off,
	input  logic [cmap_seg_pkg::WORD_W-1:0]      rd_end,
	input  logic [cmap_seg_pkg::WORD_W-1:0]      rd_start,
	input  logic [cmap_seg_pkg::WORD_W-1:0]      rd_delta,
	input  logic [cmap_seg_pkg::WORD_W-1:0]      rd_off,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output cmap_seg_pkg::result_t                res
);

	import cmap_seg_pkg::*;

	localparam int AW = $clog2(TABLE_WORDS);
	localparam int SW = $clog2(MAX_SEGMENTS + 1);
	localparam int CW = (SW > SEGCNT_W) ? SW : SEGCNT_W;
	localparam int OW = $clog2(4 * MAX_SEGMENTS + 1);
	localparam int EW = ((OW > WORD_W) ? OW : WORD_W) + 2;

	state_t              state_q, state_d;
	logic [SW-1:0]       seg_q;
	logic [SW-1:0]       idx_q;
	logic [WORD_W-1:0]   code_q;
	logic [EW-1:0]       base_st_q, base_dl_q, base_of_q;
	logic                v_s1;
	logic                oob_s1;
	logic [EW-1:0]       off_s1;
	logic [EW-1:0]       gaddr_q;
	logic [WORD_W-1:0]   delta_q;
	result_t             res_q;

	logic [SW-1:0]       seg_cl;
	logic [EW-1:0]       seg_e;
	logic [EW-1:0]       ea_idx, a_st, a_dl, a_of;
	logic                oob_cur;
	logic                hit;
	logic                exit_scan;
	logic                issue;
	logic [EW-1:0]       gaddr_calc;

	assign seg_cl = (CW'(seg_cnt) > CW'(MAX_SEGMENTS)) ? SW'(MAX_SEGMENTS) : SW'(seg_cnt);
	assign seg_e  = EW'(seg_cl);

	assign ea_idx  = EW'(idx_q);
	assign a_st    = base_st_q + ea_idx;
	assign a_dl    = base_dl_q + ea_idx;
	assign a_of    = base_of_q + ea_idx;
	assign oob_cur = a_of >= EW'(TABLE_WORDS);

	assign hit       = v_s1 && !oob_s1 && (code_q <= rd_end) && (code_q >= rd_start);
	assign exit_scan = (v_s1 && (oob_s1 || hit)) || (!v_s1 && (idx_q == seg_q));
	assign issue     = (state_q == S_SCAN) && !exit_scan && (idx_q < seg_q);

	assign gaddr_calc = off_s1 + EW'(rd_off[WORD_W-1:1]) + EW'(WORD_W'(code_q - rd_start));

	// glyph word shares the end-code port
	assign ra_end   = (state_q == S_GCHK) ? gaddr_q[AW-1:0] : ea_idx[AW-1:0];
	assign ra_start = a_st[AW-1:0];
	assign ra_delta = a_dl[AW-1:0];
	assign ra_off   = a_of[AW-1:0];

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			v_s1    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == S_IDLE)) begin
			seg_q     <= seg_cl;
			code_q    <= code_in;
			base_st_q <= seg_e + EW'(1);
			base_dl_q <= (seg_e << 1) + EW'(1);
			base_of_q <= (seg_e << 1) + seg_e + EW'(1);
			idx_q     <= '0;
		end else if (issue) begin
			idx_q <= idx_q + SW'(1);
		end
		off_s1 <= a_of;
		oob_s1 <= oob_cur;
		if ((state_q == S_SCAN) && hit) begin
			gaddr_q <= gaddr_calc;
			delta_q <= rd_delta;
		end
		case (state_q)
			S_SCAN: begin
				if (v_s1 && oob_s1) begin
					res_q <= '{glyph_id: '0, status: ST_RANGE_ERR};
				end else if (hit) begin
					res_q <= '{glyph_id: WORD_W'(rd_delta + code_q), status: ST_MAPPED};
				end else if (exit_scan) begin
					res_q <= '{glyph_id: '0, status: ST_NO_SEG};
				end
			end
			S_GCHK: begin
				res_q <= '{glyph_id: '0, status: ST_RANGE_ERR};
			end
			S_GWAIT: begin
				res_q <= '{glyph_id: (rd_end == '0) ? '0 : WORD_W'(rd_end + delta_q),
					status: ST_MAPPED};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit && (rd_off != '0)) begin
					state_d = S_GCHK;
				end else if (exit_scan) begin
					state_d = S_DONE;
				end
			end
			S_GCHK: begin
				state_d = (gaddr_q >= EW'(TABLE_WORDS)) ? S_DONE : S_GWAIT;
			end
			S_GWAIT: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`CMAP_SEG_ASSERT_NOW(a_s1_in_scan, v_s1, state_q == S_SCAN, "record in flight outside scan")
	`CMAP_SEG_ASSERT_NOW(a_gwait_after_gchk, state_q == S_GWAIT, $past(state_q) == S_GCHK, "glyph read without address check")
	`CMAP_SEG_ASSERT_NEXT(a_res_hold, (state_q == S_DONE) && !res_ready, (state_q == S_DONE) && $stable(res_q), "result dropped before transfer")

endmodule

`default_nettype wire
